// ----- hw/rtl/cna_pkg.sv -----
`timescale 1ns / 1ps

package cna_pkg;

  // Operation codes carried in the input tuser field.
  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_NEG = 3'd4,
    OP_MAG = 3'd5,
    OP_CMP = 3'd6
  } op_t;

  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  // Quotient bits produced by the divider chain (bits 32 down to 0).
  localparam int DIV_STEPS = 33;
  // Result bits produced by the square root chain.
  localparam int SQRT_STEPS = 32;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } clamp_t;

  // Products and early results after the multiplier stage.
  typedef struct packed {
    op_t                op;
    logic [31:0]        pre_re;
    logic [31:0]        pre_im;
    logic               pre_sat;
    logic               eq;
    logic signed [63:0] p0;
    logic signed [63:0] p1;
    logic signed [63:0] p2;
    logic signed [63:0] p3;
    logic signed [63:0] p4;
    logic signed [63:0] p5;
  } prod_t;

  // Sign-magnitude numerators and the divisor (or magnitude radicand).
  typedef struct packed {
    op_t         op;
    logic [31:0] pre_re;
    logic [31:0] pre_im;
    logic        pre_sat;
    logic        eq;
    logic        neg_re;
    logic        neg_im;
    logic [63:0] mag_re;
    logic [63:0] mag_im;
    logic [63:0] d;
  } num_t;

  // State of the divider and square root lanes.
  typedef struct packed {
    op_t         op;
    logic [31:0] pre_re;
    logic [31:0] pre_im;
    logic        pre_sat;
    logic        eq;
    logic        neg_re;
    logic        neg_im;
    logic        ovf_re;
    logic        ovf_im;
    logic [63:0] d;
    logic [63:0] r_re;
    logic [63:0] r_im;
    logic [32:0] lo_re;
    logic [32:0] lo_im;
    logic [32:0] q_re;
    logic [32:0] q_im;
    logic [63:0] sx;
    logic [63:0] sres;
  } div_t;

  typedef struct packed {
    logic [31:0] res_re;
    logic [31:0] res_im;
    logic        is_equal;
    logic        div_zero;
    logic        saturated;
  } res_t;

  // Saturate a sign-magnitude value to a signed 32-bit word.
  function automatic clamp_t clamp_sm(logic neg, logic [63:0] mag);
    clamp_t c;
    c.sat = 1'b0;
    c.val = mag[31:0];
    if (neg && (mag != 64'd0)) begin
      if (mag > 64'h0000_0000_8000_0000) begin
        c.sat = 1'b1;
        c.val = SAT_NEG;
      end else begin
        c.val = 32'd0 - mag[31:0];
      end
    end else if (mag > 64'h0000_0000_7FFF_FFFF) begin
      c.sat = 1'b1;
      c.val = SAT_POS;
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/cna_mul.sv -----
`timescale 1ns / 1ps

module cna_mul import cna_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid_in,
  output logic        ready_in,
  input  op_t         op,
  input  logic [31:0] a_re,
  input  logic [31:0] a_im,
  input  logic [31:0] b_re,
  input  logic [31:0] b_im,
  output logic        valid_out,
  input  logic        ready_out,
  output prod_t       data_out
);

  logic  v;
  prod_t nxt;

  logic signed [31:0] sar, sai, sbr, sbi, sx, sy;
  logic        [32:0] sum_re, sum_im;
  clamp_t             c_re, c_im;

  // Saturate a 33-bit exact sum to 32 bits.
  function automatic clamp_t clamp33(logic [32:0] s);
    clamp_t c;
    c.sat = s[32] ^ s[31];
    c.val = c.sat ? (s[32] ? SAT_NEG : SAT_POS) : s[31:0];
    return c;
  endfunction

  always_comb begin
    sar = a_re;
    sai = a_im;
    sbr = b_re;
    sbi = b_im;
    // The squaring pair serves the divisor, or operand A for the magnitude.
    sx  = (op == OP_MAG) ? sar : sbr;
    sy  = (op == OP_MAG) ? sai : sbi;

    case (op)
      OP_SUB: begin
        sum_re = {a_re[31], a_re} - {b_re[31], b_re};
        sum_im = {a_im[31], a_im} - {b_im[31], b_im};
      end
      OP_NEG: begin
        sum_re = 33'd0 - {a_re[31], a_re};
        sum_im = 33'd0 - {a_im[31], a_im};
      end
      default: begin
        sum_re = {a_re[31], a_re} + {b_re[31], b_re};
        sum_im = {a_im[31], a_im} + {b_im[31], b_im};
      end
    endcase
    c_re = clamp33(sum_re);
    c_im = clamp33(sum_im);

    nxt.op      = op;
    nxt.eq      = (op == OP_CMP) && (a_re == b_re) && (a_im == b_im);
    nxt.pre_re  = 32'd0;
    nxt.pre_im  = 32'd0;
    nxt.pre_sat = 1'b0;
    if ((op == OP_ADD) || (op == OP_SUB) || (op == OP_NEG)) begin
      nxt.pre_re  = c_re.val;
      nxt.pre_im  = c_im.val;
      nxt.pre_sat = c_re.sat | c_im.sat;
    end
    nxt.p0 = sar * sbr;
    nxt.p1 = sai * sbi;
    nxt.p2 = sai * sbr;
    nxt.p3 = sar * sbi;
    nxt.p4 = sx * sx;
    nxt.p5 = sy * sy;
  end

  assign ready_in  = !v || ready_out;
  assign valid_out = v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (ready_in) begin
      v <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_in && valid_in) begin
      data_out <= nxt;
    end
  end

endmodule

// ----- hw/rtl/cna_sum.sv -----
`timescale 1ns / 1ps

module cna_sum import cna_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  valid_in,
  output logic  ready_in,
  input  prod_t data_in,
  output logic  valid_out,
  input  logic  ready_out,
  output num_t  data_out
);

  typedef struct packed {
    op_t                op;
    logic [31:0]        pre_re;
    logic [31:0]        pre_im;
    logic               pre_sat;
    logic               eq;
    logic signed [64:0] s_re;
    logic signed [64:0] s_im;
    logic [63:0]        d;
  } sums_t;

  sums_t sums, sums_next;
  num_t  num_next;
  logic  v2, v3, rdy2, rdy3;
  logic [64:0] neg_re_full, neg_im_full;
  clamp_t c_re, c_im;

  // First stage: exact sums of the product pairs.
  always_comb begin
    sums_next.op      = data_in.op;
    sums_next.pre_re  = data_in.pre_re;
    sums_next.pre_im  = data_in.pre_im;
    sums_next.pre_sat = data_in.pre_sat;
    sums_next.eq      = data_in.eq;
    if (data_in.op == OP_MUL) begin
      sums_next.s_re = {data_in.p0[63], data_in.p0} - {data_in.p1[63], data_in.p1};
      sums_next.s_im = {data_in.p2[63], data_in.p2} + {data_in.p3[63], data_in.p3};
    end else begin
      sums_next.s_re = {data_in.p0[63], data_in.p0} + {data_in.p1[63], data_in.p1};
      sums_next.s_im = {data_in.p2[63], data_in.p2} - {data_in.p3[63], data_in.p3};
    end
    sums_next.d = data_in.p4 + data_in.p5;
  end

  // Second stage: sign and magnitude; the multiply result is finished here.
  always_comb begin
    neg_re_full = 65'd0 - sums.s_re;
    neg_im_full = 65'd0 - sums.s_im;
    num_next.op     = sums.op;
    num_next.eq     = sums.eq;
    num_next.d      = sums.d;
    num_next.neg_re = sums.s_re[64];
    num_next.neg_im = sums.s_im[64];
    num_next.mag_re = sums.s_re[64] ? neg_re_full[63:0] : sums.s_re[63:0];
    num_next.mag_im = sums.s_im[64] ? neg_im_full[63:0] : sums.s_im[63:0];
    c_re = clamp_sm(num_next.neg_re, num_next.mag_re >> FRAC_BITS);
    c_im = clamp_sm(num_next.neg_im, num_next.mag_im >> FRAC_BITS);
    if (sums.op == OP_MUL) begin
      num_next.pre_re  = c_re.val;
      num_next.pre_im  = c_im.val;
      num_next.pre_sat = c_re.sat | c_im.sat;
    end else begin
      num_next.pre_re  = sums.pre_re;
      num_next.pre_im  = sums.pre_im;
      num_next.pre_sat = sums.pre_sat;
    end
  end

  assign rdy3      = !v3 || ready_out;
  assign rdy2      = !v2 || rdy3;
  assign ready_in  = rdy2;
  assign valid_out = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy2) begin
        v2 <= valid_in;
      end
      if (rdy3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && valid_in) begin
      sums <= sums_next;
    end
    if (rdy3 && v2) begin
      data_out <= num_next;
    end
  end

endmodule

// ----- hw/rtl/cna_iter.sv -----
`timescale 1ns / 1ps

module cna_iter import cna_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic valid_in,
  output logic ready_in,
  input  num_t data_in,
  output logic valid_out,
  input  logic ready_out,
  output div_t data_out
);

  // The quotient integer part above bit 32 is checked against the divisor.
  localparam int SHIFT_HI = 33 - FRAC_BITS;

  div_t                 st   [DIV_STEPS+1];
  div_t                 nxt  [DIV_STEPS+1];
  logic [DIV_STEPS:0]   v;
  logic [DIV_STEPS+1:0] rdy;
  logic [63:0]          hi_re, hi_im;

  // Trial bit of the square root for one stage; zero past the last root bit.
  function automatic logic [63:0] sq_bit(int i);
    if (i <= SQRT_STEPS) begin
      return 64'd1 << (2 * (SQRT_STEPS - i));
    end
    return 64'd0;
  endfunction

  // One restoring divide step on both lanes and, where enabled, one root step.
  function automatic div_t div_step(div_t x, logic [63:0] sq);
    div_t        y;
    logic [64:0] r2_re, r2_im;
    logic [63:0] t;
    y = x;
    r2_re = {x.r_re, x.lo_re[32]};
    r2_im = {x.r_im, x.lo_im[32]};
    if (r2_re >= {1'b0, x.d}) begin
      y.r_re = 64'(r2_re - {1'b0, x.d});
      y.q_re = {x.q_re[31:0], 1'b1};
    end else begin
      y.r_re = r2_re[63:0];
      y.q_re = {x.q_re[31:0], 1'b0};
    end
    if (r2_im >= {1'b0, x.d}) begin
      y.r_im = 64'(r2_im - {1'b0, x.d});
      y.q_im = {x.q_im[31:0], 1'b1};
    end else begin
      y.r_im = r2_im[63:0];
      y.q_im = {x.q_im[31:0], 1'b0};
    end
    y.lo_re = {x.lo_re[31:0], 1'b0};
    y.lo_im = {x.lo_im[31:0], 1'b0};
    if (sq != 64'd0) begin
      t = x.sres + sq;
      if (x.sx >= t) begin
        y.sx   = x.sx - t;
        y.sres = (x.sres >> 1) + sq;
      end else begin
        y.sres = x.sres >> 1;
      end
    end
    return y;
  endfunction

  always_comb begin
    hi_re = data_in.mag_re >> SHIFT_HI;
    hi_im = data_in.mag_im >> SHIFT_HI;
    nxt[0].op      = data_in.op;
    nxt[0].pre_re  = data_in.pre_re;
    nxt[0].pre_im  = data_in.pre_im;
    nxt[0].pre_sat = data_in.pre_sat;
    nxt[0].eq      = data_in.eq;
    nxt[0].neg_re  = data_in.neg_re;
    nxt[0].neg_im  = data_in.neg_im;
    nxt[0].ovf_re  = hi_re >= data_in.d;
    nxt[0].ovf_im  = hi_im >= data_in.d;
    nxt[0].d       = data_in.d;
    nxt[0].r_re    = hi_re;
    nxt[0].r_im    = hi_im;
    nxt[0].lo_re   = data_in.mag_re[32:0] << FRAC_BITS;
    nxt[0].lo_im   = data_in.mag_im[32:0] << FRAC_BITS;
    nxt[0].q_re    = 33'd0;
    nxt[0].q_im    = 33'd0;
    nxt[0].sx      = data_in.d;
    nxt[0].sres    = 64'd0;
    for (int i = 1; i <= DIV_STEPS; i++) begin
      nxt[i] = div_step(st[i-1], sq_bit(i));
    end
  end

  // A stage can take a new word when it is empty or its word moves on.
  always_comb begin
    rdy[DIV_STEPS+1] = ready_out;
    for (int i = DIV_STEPS; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  assign ready_in  = rdy[0];
  assign valid_out = v[DIV_STEPS];
  assign data_out  = st[DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= valid_in;
      end
      for (int i = 1; i <= DIV_STEPS; i++) begin
        if (rdy[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && valid_in) begin
      st[0] <= nxt[0];
    end
    for (int i = 1; i <= DIV_STEPS; i++) begin
      if (rdy[i] && v[i-1]) begin
        st[i] <= nxt[i];
      end
    end
  end

endmodule

// ----- hw/rtl/cna_out.sv -----
`timescale 1ns / 1ps

module cna_out import cna_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic valid_in,
  output logic ready_in,
  input  div_t data_in,
  output logic valid_out,
  input  logic ready_out,
  output res_t data_out
);

  logic   v;
  res_t   res_next;
  clamp_t c_re, c_im;

  always_comb begin
    c_re = data_in.ovf_re ? clamp_sm(data_in.neg_re, 64'h0000_0001_0000_0000)
                          : clamp_sm(data_in.neg_re, {31'd0, data_in.q_re});
    c_im = data_in.ovf_im ? clamp_sm(data_in.neg_im, 64'h0000_0001_0000_0000)
                          : clamp_sm(data_in.neg_im, {31'd0, data_in.q_im});
    res_next = '0;
    case (data_in.op) inside
      OP_ADD, OP_SUB, OP_MUL, OP_NEG, OP_CMP: begin
        res_next.res_re    = data_in.pre_re;
        res_next.res_im    = data_in.pre_im;
        res_next.saturated = data_in.pre_sat;
        res_next.is_equal  = data_in.eq;
      end
      OP_DIV: begin
        if (data_in.d == 64'd0) begin
          res_next.div_zero = 1'b1;
        end else begin
          res_next.res_re    = c_re.val;
          res_next.res_im    = c_im.val;
          res_next.saturated = c_re.sat | c_im.sat;
        end
      end
      OP_MAG: begin
        c_re               = clamp_sm(1'b0, data_in.sres);
        res_next.res_re    = c_re.val;
        res_next.saturated = c_re.sat;
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  assign ready_in  = !v || ready_out;
  assign valid_out = v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (ready_in) begin
      v <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_in && valid_in) begin
      data_out <= res_next;
    end
  end

endmodule

// ----- hw/rtl/complex_number_alu.sv -----
`timescale 1ns / 1ps

// Complex arithmetic unit on signed fixed-point operands.
// The input stream carries one request per word: operand A and operand B in
// tdata and the operation code in tuser (add, subtract, multiply, divide,
// negate A, magnitude of A, equality compare). The output stream carries one
// result word per request, in request order, with the real and imaginary
// parts in tdata and the equal, divide-by-zero and saturation flags in tuser.
// Every request passes 38 register stages: one multiplier stage, two summing
// stages, a chain of 34 divider and square root stages (a set-up stage, then
// one quotient bit per stage and one root bit in all but the last), and the
// output register. A new word is accepted every cycle while the output side
// keeps up. Each stage holds its word while the next one is full, so a stall
// on the output side fills the empty stages first and only then drops tready
// on the input side; no word is lost or repeated.
// Reset clears all valid bits; the pipeline is empty and ready at once.
// A divide with a zero divisor returns zero parts and raises the divide-by-zero
// flag. Parts that leave the 32-bit range are clamped and raise the saturation
// flag.
module complex_number_alu import cna_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // a_re [31:0], a_im [63:32], b_re [95:64], b_im [127:96]
  input  logic [127:0] s_axis_tdata,
  // req_type [2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // res_re [31:0], res_im [63:32]
  output logic [63:0]  m_axis_tdata,
  // is_equal [0], div_zero [1], saturated [2]
  output logic [2:0]   m_axis_tuser
);

  logic  mul_valid, mul_ready;
  logic  sum_valid, sum_ready;
  logic  iter_valid, iter_ready;
  prod_t prod;
  num_t  num;
  div_t  dstate;
  res_t  res;

  // Stage 1: all six products of the operand parts, plus the add, subtract, negate and compare results.
  cna_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (s_axis_tvalid),
    .ready_in  (s_axis_tready),
    .op        (op_t'(s_axis_tuser)),
    .a_re      (s_axis_tdata[31:0]),
    .a_im      (s_axis_tdata[63:32]),
    .b_re      (s_axis_tdata[95:64]),
    .b_im      (s_axis_tdata[127:96]),
    .valid_out (mul_valid),
    .ready_out (mul_ready),
    .data_out  (prod)
  );

  // Stages 2 and 3: numerators, divisor and the finished multiply result.
  cna_sum #(
    .FRAC_BITS (FRAC_BITS)
  ) u_sum (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (mul_valid),
    .ready_in  (mul_ready),
    .data_in   (prod),
    .valid_out (sum_valid),
    .ready_out (sum_ready),
    .data_out  (num)
  );

  // Divider and square root chain.
  cna_iter #(
    .FRAC_BITS (FRAC_BITS)
  ) u_iter (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (sum_valid),
    .ready_in  (sum_ready),
    .data_in   (num),
    .valid_out (iter_valid),
    .ready_out (iter_ready),
    .data_out  (dstate)
  );

  // Result selection, final saturation and the output register.
  cna_out u_out (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (iter_valid),
    .ready_in  (iter_ready),
    .data_in   (dstate),
    .valid_out (m_axis_tvalid),
    .ready_out (m_axis_tready),
    .data_out  (res)
  );

  assign m_axis_tdata = {res.res_im, res.res_re};
  assign m_axis_tuser = {res.saturated, res.div_zero, res.is_equal};

`ifndef SYNTHESIS
  // A zero divisor yields zero parts and never a saturation.
  a_div_zero_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[1]) |->
      (m_axis_tdata == 64'd0) && !m_axis_tuser[2])
    else $error("divide-by-zero result is not clean");

  // Compare and divide flags belong to different operations.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("equal and divide-by-zero flags both set");

  // A saturated result has at least one part at a range limit.
  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[2]) |->
      ((m_axis_tdata[31:0] == SAT_POS) || (m_axis_tdata[31:0] == SAT_NEG) ||
       (m_axis_tdata[63:32] == SAT_POS) || (m_axis_tdata[63:32] == SAT_NEG)))
    else $error("saturation flag without a clamped part");

  // A compare result that reports equality carries zero parts.
  a_equal_zero_parts: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == 64'd0))
    else $error("compare result has nonzero parts");
`endif

endmodule

// ----- test/cna_checker.sv -----
`timescale 1ns / 1ps

// Watches both streams of the complex ALU, predicts each result word from the
// accepted request and compares it with what comes out, in order.
module cna_checker import cna_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,
  input  logic [2:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [63:0]  m_axis_tdata,
  input  logic [2:0]   m_axis_tuser,
  output int           errors,
  output int           pending
);

  res_t results_due[$];

  // Clamp an exact value to the signed 32-bit range; bit 32 is the flag.
  function automatic logic [32:0] clamp_part(logic signed [127:0] v);
    if (v > 128'sh7FFF_FFFF) return {1'b1, SAT_POS};
    if (v < -128'sh8000_0000) return {1'b1, SAT_NEG};
    return {1'b0, v[31:0]};
  endfunction

  // Exact value scaled down by the fraction bits, truncated toward zero.
  function automatic logic signed [127:0] scale_down(logic signed [127:0] v);
    if (v < 0) return -((-v) >>> FRAC_BITS);
    return v >>> FRAC_BITS;
  endfunction

  // Numerator * 2^FRAC_BITS / d, truncated toward zero.
  function automatic logic signed [127:0] scaled_quot(logic signed [127:0] n,
                                                      logic signed [127:0] d);
    logic signed [127:0] q;
    q = ((n < 0 ? -n : n) <<< FRAC_BITS) / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] s);
    logic [63:0] r;
    logic [63:0] trial;
    r = 64'd0;
    for (int i = 31; i >= 0; i--) begin
      trial = r | (64'd1 << i);
      if (trial * trial <= s) r = trial;
    end
    return r;
  endfunction

  function automatic res_t alu_result(logic [2:0] code, logic signed [31:0] ar,
                                      logic signed [31:0] ai, logic signed [31:0] br,
                                      logic signed [31:0] bi);
    res_t r;
    logic [32:0] cr, ci;
    logic signed [127:0] xr, xi, yr, yi, d;
    xr = ar; xi = ai; yr = br; yi = bi;
    r = '0;
    cr = '0;
    ci = '0;
    case (code)
      OP_ADD: begin
        cr = clamp_part(xr + yr);
        ci = clamp_part(xi + yi);
      end
      OP_SUB: begin
        cr = clamp_part(xr - yr);
        ci = clamp_part(xi - yi);
      end
      OP_MUL: begin
        cr = clamp_part(scale_down(xr * yr - xi * yi));
        ci = clamp_part(scale_down(xi * yr + xr * yi));
      end
      OP_DIV: begin
        d = yr * yr + yi * yi;
        if (d == 0) begin
          r.div_zero = 1'b1;
        end else begin
          cr = clamp_part(scaled_quot(xr * yr + xi * yi, d));
          ci = clamp_part(scaled_quot(xi * yr - xr * yi, d));
        end
      end
      OP_NEG: begin
        cr = clamp_part(-xr);
        ci = clamp_part(-xi);
      end
      OP_MAG: begin
        d = xr * xr + xi * xi;
        cr = clamp_part({64'd0, floor_sqrt(d[63:0])});
      end
      OP_CMP: r.is_equal = (ar == br) && (ai == bi);
      default: ;
    endcase
    r.res_re = cr[31:0];
    r.res_im = ci[31:0];
    r.saturated = cr[32] | ci[32];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    errors++;
  endtask

  initial errors = 0;
  assign pending = results_due.size();

  always @(posedge clk) begin
    res_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (results_due.size() == 0) begin
          $display("%0t: result word with nothing outstanding", $realtime);
          errors++;
        end else begin
          want = results_due.pop_front();
          if (m_axis_tdata[31:0] !== want.res_re)
            report_mismatch("res_re", m_axis_tdata[31:0], want.res_re);
          if (m_axis_tdata[63:32] !== want.res_im)
            report_mismatch("res_im", m_axis_tdata[63:32], want.res_im);
          if (m_axis_tuser[0] !== want.is_equal)
            report_mismatch("is_equal", 32'(m_axis_tuser[0]), 32'(want.is_equal));
          if (m_axis_tuser[1] !== want.div_zero)
            report_mismatch("div_zero", 32'(m_axis_tuser[1]), 32'(want.div_zero));
          if (m_axis_tuser[2] !== want.saturated)
            report_mismatch("saturated", 32'(m_axis_tuser[2]), 32'(want.saturated));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        results_due.push_back(alu_result(s_axis_tuser, s_axis_tdata[31:0],
            s_axis_tdata[63:32], s_axis_tdata[95:64], s_axis_tdata[127:96]));
    end
  end

endmodule

// ----- test/tb_complex_number_alu.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the complex ALU. The checker beside the block does
// all prediction and comparison; this module only feeds words, drives the
// receiver ready and watches for the end.
module tb_complex_number_alu;
  import cna_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = OP_ADD;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  int           errors;
  int           pending;

  // Idle rates in percent for each side, and a long receiver hold-off.
  int send_idle = 0;
  int recv_idle = 0;
  int recv_hold = 0;

  always #1 clk = ~clk;

  complex_number_alu dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  cna_checker checker_i (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .errors(errors), .pending(pending)
  );

  // The receiver decides its ready once per cycle. A hold-off counts down in
  // this process and keeps ready low while the sender keeps offering words.
  always @(posedge clk) begin
    if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Offers one word; tvalid stays high between back-to-back words and only
  // drops when the sender decides to idle.
  task automatic send_word(op_t code, logic [31:0] ar, logic [31:0] ai,
                           logic [31:0] br, logic [31:0] bi);
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= code;
    s_axis_tdata <= {bi, br, ai, ar};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Operand part: full random, a small Q16.16 value, or an extreme.
  function automatic logic [31:0] pick_part();
    case ($urandom_range(5))
      0, 1: return $urandom;
      2: return {{14{1'($urandom_range(1))}}, 18'($urandom)};
      3: return {{8{1'($urandom_range(1))}}, 24'($urandom)};
      4: return 32'($signed($urandom_range(8)) - 4) <<< 16;
      default: begin
        case ($urandom_range(4))
          0: return SAT_POS;
          1: return SAT_NEG;
          2: return 32'h0;
          3: return 32'hFFFF_FFFF;
          default: return 32'h0001_0000;
        endcase
      end
    endcase
  endfunction

  task automatic send_random();
    op_t code;
    logic [31:0] ar, ai, br, bi;
    code = op_t'($urandom_range(OP_CMP));
    ar = pick_part();
    ai = pick_part();
    br = pick_part();
    bi = pick_part();
    // Zero divisors and equal operand pairs need help to show up.
    if (code == OP_DIV && $urandom_range(9) == 0) begin
      br = '0;
      bi = '0;
    end
    if (code == OP_CMP && $urandom_range(1) == 0) begin
      br = ar;
      bi = ai;
      if ($urandom_range(2) == 0) bi[$urandom_range(31)] ^= 1'b1;
    end
    send_word(code, ar, ai, br, bi);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words: range ends, every operation, zero divisor, equality.
    send_word(OP_ADD, SAT_POS, SAT_NEG, 32'd1, 32'hFFFF_FFFF);
    send_word(OP_ADD, SAT_NEG, SAT_POS, SAT_NEG, SAT_POS);
    send_word(OP_SUB, SAT_NEG, SAT_POS, 32'd1, 32'hFFFF_FFFF);
    send_word(OP_SUB, 32'h0003_0000, 32'h0, 32'h0001_8000, 32'h0002_0000);
    send_word(OP_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hFFFF_0000);
    send_word(OP_MUL, SAT_NEG, SAT_NEG, SAT_NEG, SAT_POS);
    send_word(OP_MUL, 32'hFFFF_FFFF, 32'h0, 32'h0000_8000, 32'h0);
    send_word(OP_MUL, SAT_POS, SAT_POS, SAT_POS, SAT_POS);
    send_word(OP_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);
    send_word(OP_DIV, 32'h0005_0000, 32'h0, 32'h0002_0000, 32'h0);
    send_word(OP_DIV, 32'hFFFF_0000, 32'h0001_0000, 32'h0, 32'hFFFF_0000);
    send_word(OP_DIV, SAT_POS, SAT_NEG, 32'd1, 32'd0);
    send_word(OP_DIV, SAT_NEG, SAT_NEG, SAT_NEG, SAT_NEG);
    send_word(OP_DIV, 32'd7, 32'd0, 32'd3, 32'd0);
    send_word(OP_NEG, SAT_NEG, SAT_POS, 32'h0, 32'h0);
    send_word(OP_NEG, 32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 32'h0);
    send_word(OP_MAG, 32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0);
    send_word(OP_MAG, SAT_NEG, SAT_NEG, 32'h0, 32'h0);
    send_word(OP_MAG, SAT_POS, 32'h0, 32'h0, 32'h0);
    send_word(OP_MAG, 32'h0, 32'h0, 32'h0, 32'h0);
    send_word(OP_CMP, SAT_NEG, SAT_POS, SAT_NEG, SAT_POS);
    send_word(OP_CMP, 32'h1, 32'h2, 32'h1, 32'h3);
    send_word(OP_CMP, 32'h0, 32'h0, 32'h0, 32'h0);

    // Random words in three idle phases.
    send_idle = 20;
    recv_idle = 67;
    repeat (300) send_random();
    send_idle = 67;
    recv_idle = 20;
    repeat (300) send_random();

    // The sender pauses until the pipeline has drained.
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);

    send_idle = 0;
    recv_idle = 0;
    // A long hold-off fills the pipeline and must stall the input side.
    recv_hold = 120;
    repeat (350) send_random();
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- complex_number_alu.f -----
hw/rtl/cna_pkg.sv
hw/rtl/cna_mul.sv
hw/rtl/cna_sum.sv
hw/rtl/cna_iter.sv
hw/rtl/cna_out.sv
hw/rtl/complex_number_alu.sv
test/cna_checker.sv
test/tb_complex_number_alu.sv
